### design/mse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg
// Shared opcodes, function codes, register indexes, reset values and the
// structs passed between the execute core's modules.
// ----------------------------------------------------------------------------
package mse_pkg;

  // primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_SLTI  = 6'h0a;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2b;

  // R-type function codes
  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_SRL = 6'h02;
  localparam logic [5:0] FN_JR  = 6'h08;
  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_SUB = 6'h22;
  localparam logic [5:0] FN_AND = 6'h24;
  localparam logic [5:0] FN_OR  = 6'h25;
  localparam logic [5:0] FN_NOR = 6'h27;
  localparam logic [5:0] FN_SLT = 6'h2a;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSTR_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE   = 2'd2;

  localparam logic [31:0] TEXT_START_RST = 32'h0040_0000;
  localparam logic [31:0] DATA_BASE_RST  = 32'h1000_0000;
  localparam logic [31:0] PC_REGION_MASK = 32'hF000_0000;
  localparam int          ICNT_W         = 17;

  localparam int          NUM_REGS = 32;
  localparam int          REG_AW   = 5;
  localparam logic [4:0]  RA_INDEX = 5'd31;

  localparam int DMEM_WORDS_DEF = 1024;

  // outcome of one instruction, before the load data is merged
  typedef struct packed {
    logic [31:0] next_pc;
    logic        wr;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic        is_load;
    logic        st;
    logic [31:0] addr;
    logic [31:0] sdata;
  } exec_t;

  // register file write port
  typedef struct packed {
    logic        we;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

### design/mse_regfile.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mse_regfile
// 32 x 32 general register file, two synchronous read ports, one write port.
// Per-entry written bits make unwritten entries (and r0) read as zero.
// ----------------------------------------------------------------------------
module mse_regfile (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [4:0]             rd_addr_a,
  input  wire logic [4:0]             rd_addr_b,
  input  wire mse_pkg::rf_wr_t        wr,
  output logic [31:0]                 rd_data_a,
  output logic [31:0]                 rd_data_b
);
  import mse_pkg::*;

  logic [31:0]         mem [NUM_REGS];
  logic [NUM_REGS-1:0] written;
  logic [31:0]         q_a;
  logic [31:0]         q_b;
  logic                ok_a;
  logic                ok_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      ok_a    <= 1'b0;
      ok_b    <= 1'b0;
    end else begin
      if (wr.we) begin
        written[wr.idx] <= 1'b1;
      end
      ok_a <= written[rd_addr_a];
      ok_b <= written[rd_addr_b];
    end
  end

  // read returns the value before a write at the same edge
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.idx] <= wr.data;
    end
    q_a <= mem[rd_addr_a];
    q_b <= mem[rd_addr_b];
  end

  assign rd_data_a = ok_a ? q_a : '0;
  assign rd_data_b = ok_b ? q_b : '0;

endmodule
`default_nettype wire

### design/mse_dmem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mse_dmem
// Word data memory, single port, registered read. A clearing pass after
// reset zeroes every word, one per cycle, while busy is high.
// ----------------------------------------------------------------------------
module mse_dmem #(
  parameter int WORDS = mse_pkg::DMEM_WORDS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(WORDS)-1:0] addr,
  input  wire logic [31:0]              wdata,
  output logic [31:0]                   rdata,
  output logic                          busy
);
  import mse_pkg::*;

  localparam int AW = $clog2(WORDS);

  logic [31:0]   mem [WORDS];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(WORDS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

### design/mse_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mse_alu
// Instruction decode and execute: ALU result, register write target, store
// request and next PC for one instruction.
// ----------------------------------------------------------------------------
module mse_alu (
  input  wire logic [31:0]    instr,
  input  wire logic [31:0]    a,
  input  wire logic [31:0]    b,
  input  wire logic [31:0]    pc,
  input  wire logic [31:0]    br_off,
  output mse_pkg::exec_t      ex
);
  import mse_pkg::*;

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] imm_s;
  logic [31:0] imm_z;
  logic [31:0] pc4;
  logic [31:0] jtarget;
  logic [31:0] br_target;

  assign op        = instr[31:26];
  assign rt        = instr[20:16];
  assign rd        = instr[15:11];
  assign sh        = instr[10:6];
  assign fn        = instr[5:0];
  assign imm_s     = sext16(instr[15:0]);
  assign imm_z     = {16'b0, instr[15:0]};
  assign pc4       = pc + 32'd4;
  assign br_target = pc + br_off;   // br_off already includes the +4
  assign jtarget   = (pc4 & PC_REGION_MASK) | {4'b0, instr[25:0], 2'b00};

  always_comb begin
    ex         = '0;
    ex.next_pc = pc4;
    unique case (op)
      OP_RTYPE: begin
        unique case (fn)
          FN_ADD: begin ex.wr = 1'b1; ex.widx = rd; ex.wval = a + b; end
          FN_SUB: begin ex.wr = 1'b1; ex.widx = rd; ex.wval = a - b; end
          FN_AND: begin ex.wr = 1'b1; ex.widx = rd; ex.wval = a & b; end
          FN_OR:  begin ex.wr = 1'b1; ex.widx = rd; ex.wval = a | b; end
          FN_NOR: begin ex.wr = 1'b1; ex.widx = rd; ex.wval = ~(a | b); end
          FN_SLT: begin
            ex.wr   = 1'b1;
            ex.widx = rd;
            ex.wval = {31'b0, $signed(a) < $signed(b)};
          end
          FN_SLL: begin ex.wr = 1'b1; ex.widx = rd; ex.wval = b << sh; end
          FN_SRL: begin ex.wr = 1'b1; ex.widx = rd; ex.wval = b >> sh; end
          FN_JR:  ex.next_pc = a;
          default: ;
        endcase
      end
      OP_ADDI: begin ex.wr = 1'b1; ex.widx = rt; ex.wval = a + imm_s; end
      OP_ANDI: begin ex.wr = 1'b1; ex.widx = rt; ex.wval = a & imm_z; end
      OP_ORI:  begin ex.wr = 1'b1; ex.widx = rt; ex.wval = a | imm_z; end
      OP_SLTI: begin
        ex.wr   = 1'b1;
        ex.widx = rt;
        ex.wval = {31'b0, $signed(a) < $signed(imm_s)};
      end
      OP_LUI:  begin ex.wr = 1'b1; ex.widx = rt; ex.wval = {instr[15:0], 16'b0}; end
      OP_LW:   begin ex.wr = 1'b1; ex.widx = rt; ex.is_load = 1'b1; end
      OP_SW: begin
        ex.st    = 1'b1;
        ex.addr  = a + imm_s;
        ex.sdata = b;
      end
      OP_BEQ:  if (a == b) ex.next_pc = br_target;
      OP_BNE:  if (a != b) ex.next_pc = br_target;
      OP_J:    ex.next_pc = jtarget;
      OP_JAL: begin
        ex.wr      = 1'b1;
        ex.widx    = RA_INDEX;
        ex.wval    = pc4;
        ex.next_pc = jtarget;
      end
      default: ;
    endcase
    // r0 is hardwired: drop the write and report nothing
    if (ex.wr && ex.widx == '0) begin
      ex.wr      = 1'b0;
      ex.wval    = '0;
      ex.is_load = 1'b0;
    end
  end

endmodule
`default_nettype wire

### design/mips32_subset_execute_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mips32_subset_execute_core
// Executes one MIPS-32 subset instruction per transaction and reports the
// next PC, halt, register write and store for it.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_ready  | instr_word
//  out     | out_valid/out_ready| next_pc, halted, reg_write_*, store_*
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// One instruction per clock sustained while out_ready stays high. An accepted
// instruction passes the decode/execute stage, memory stage and output register.
// The register file and data memory are synchronous RAMs with registered reads;
// the memory stage result and the last register write are forwarded to execute.
// After reset the data memory is zeroed by a pass over all DMEM_WORDS words;
// in_ready stays low until it ends. Stages move independently, so input is
// still taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module mips32_subset_execute_core #(
  parameter int DMEM_WORDS = mse_pkg::DMEM_WORDS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [31:0]                    instr_word,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [31:0]                         next_pc,
  output logic                                halted,
  output logic                                reg_write_valid,
  output logic [4:0]                          reg_write_index,
  output logic [31:0]                         reg_write_value,
  output logic                                store_valid,
  output logic [31:0]                         store_addr,
  output logic [31:0]                         store_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                    cfg_data
);
  import mse_pkg::*;

  localparam int DM_AW = $clog2(DMEM_WORDS);

  // configuration and architectural PC
  logic [31:0]       text_start;
  logic [ICNT_W-1:0] instr_count;
  logic [31:0]       data_base;
  logic [31:0]       pc;

  // execute stage
  logic        s1_valid;
  logic [31:0] s1_instr;
  logic [31:0] s1_boff;
  logic [31:0] s1_doff;
  logic        s1_move;

  // memory stage
  logic        s2_valid;
  exec_t       s2_ex;
  logic        s2_in_range;
  logic        s2_move;
  logic        s2_ready;
  logic [31:0] s2_wval;

  logic        accept;
  logic [31:0] rd_sel;
  logic [31:0] rf_a;
  logic [31:0] rf_b;
  rf_wr_t      rf_wr;
  rf_wr_t      wb_last;
  logic [31:0] op_a;
  logic [31:0] op_b;
  exec_t       ex;

  logic [31:0]      dm_sum;
  logic [29:0]      dm_word;
  logic             dm_in_range;
  logic             dm_en;
  logic [31:0]      dm_rdata;
  logic             clr_busy;

  logic [31:0] pc_ofs;
  logic        halt_next;

  assign cfg_ready = 1'b1;

  // handshake and stage movement
  assign s2_move  = s2_valid && (!out_valid || out_ready);
  assign s2_ready = !s2_valid || s2_move;
  assign s1_move  = s1_valid && s2_ready;
  assign in_ready = !clr_busy && (!s1_valid || s1_move);
  assign accept   = in_valid && in_ready;

  // configuration and PC
  always_ff @(posedge clk) begin
    if (rst) begin
      text_start  <= TEXT_START_RST;
      instr_count <= '0;
      data_base   <= DATA_BASE_RST;
      pc          <= TEXT_START_RST;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_TEXT_START:  text_start  <= cfg_data;
          CFG_INSTR_COUNT: instr_count <= cfg_data[ICNT_W-1:0];
          CFG_DATA_BASE:   data_base   <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_valid && cfg_index == CFG_TEXT_START) begin
        pc <= cfg_data;
      end else if (s1_move) begin
        pc <= ex.next_pc;
      end
    end
  end

  // execute stage registers; offsets are folded in ahead of time
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr <= instr_word;
      s1_boff  <= {{14{instr_word[15]}}, instr_word[15:0], 2'b00} + 32'd4;
      s1_doff  <= sext16(instr_word[15:0]) - data_base;
    end
  end

  // register file is re-read every cycle for whatever sits in execute
  assign rd_sel = accept ? instr_word : s1_instr;

  mse_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_addr_a (rd_sel[25:21]),
    .rd_addr_b (rd_sel[20:16]),
    .wr        (rf_wr),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b)
  );

  // write that landed at the last edge, missed by that edge's read
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_last <= '0;
    end else begin
      wb_last <= rf_wr;
    end
  end

  // operand forwarding: memory stage first, then last writeback
  always_comb begin
    op_a = rf_a;
    op_b = rf_b;
    if (wb_last.we && wb_last.idx == s1_instr[25:21]) op_a = wb_last.data;
    if (wb_last.we && wb_last.idx == s1_instr[20:16]) op_b = wb_last.data;
    if (s2_valid && s2_ex.wr && s2_ex.widx == s1_instr[25:21]) op_a = s2_wval;
    if (s2_valid && s2_ex.wr && s2_ex.widx == s1_instr[20:16]) op_b = s2_wval;
  end

  mse_alu u_alu (
    .instr  (s1_instr),
    .a      (op_a),
    .b      (op_b),
    .pc     (pc),
    .br_off (s1_boff),
    .ex     (ex)
  );

  // data memory access; out-of-range words read 0 and ignore stores
  assign dm_sum      = op_a + s1_doff;
  assign dm_word     = dm_sum[31:2];
  assign dm_in_range = dm_word < 30'(DMEM_WORDS);
  assign dm_en       = s1_move && (ex.is_load || ex.st) && dm_in_range;

  mse_dmem #(
    .WORDS (DMEM_WORDS)
  ) u_dmem (
    .clk   (clk),
    .rst   (rst),
    .en    (dm_en),
    .we    (ex.st),
    .addr  (dm_word[DM_AW-1:0]),
    .wdata (ex.sdata),
    .rdata (dm_rdata),
    .busy  (clr_busy)
  );

  // memory stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_ex       <= ex;
      s2_in_range <= dm_in_range;
    end
  end

  always_comb begin
    if (!s2_ex.wr) begin
      s2_wval = '0;
    end else if (s2_ex.is_load) begin
      s2_wval = s2_in_range ? dm_rdata : '0;
    end else begin
      s2_wval = s2_ex.wval;
    end
  end

  assign rf_wr.we   = s2_move && s2_ex.wr;
  assign rf_wr.idx  = s2_ex.widx;
  assign rf_wr.data = s2_wval;

  assign pc_ofs    = s2_ex.next_pc - text_start;
  assign halt_next = pc_ofs[31:2] >= 30'(instr_count);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      next_pc         <= s2_ex.next_pc;
      halted          <= halt_next;
      reg_write_valid <= s2_ex.wr;
      reg_write_index <= s2_ex.widx;
      reg_write_value <= s2_wval;
      store_valid     <= s2_ex.st;
      store_addr      <= s2_ex.addr;
      store_data      <= s2_ex.sdata;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !in_ready)
    else $error("instruction accepted during data memory clear");

  a_no_r0_write: assert property (@(posedge clk) disable iff (rst)
    rf_wr.we |-> rf_wr.idx != '0)
    else $error("register zero written");

  a_quiet_no_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reg_write_valid) |-> (reg_write_index == '0 && reg_write_value == '0))
    else $error("register write fields not cleared");

  a_s2_held: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_move) |=> (s2_valid && $stable(s2_ex)))
    else $error("memory stage lost an instruction while stalled");

  a_dmem_single_use: assert property (@(posedge clk) disable iff (rst)
    dm_en |-> !clr_busy)
    else $error("data memory accessed during clear");

endmodule
`default_nettype wire
